FILE: sv/ssr_pkg.sv
`timescale 1ns / 1ps

package ssr_pkg;

    localparam int MaxPattern     = 8;
    localparam int MaxReplacement = 8;
    localparam int WindowDepth    = 8;
    localparam int ByteWidth      = 8;
    localparam int TextWidth      = WindowDepth * ByteWidth;
    localparam int LenWidth       = 4;
    localparam int FillWidth      = $clog2(WindowDepth);
    localparam int CfgIndexWidth  = 8;

    localparam logic [LenWidth-1:0] PatLimit =
        LenWidth'((MaxPattern < WindowDepth) ? MaxPattern : WindowDepth);
    localparam logic [LenWidth-1:0] ReplLimit =
        LenWidth'((MaxReplacement < WindowDepth) ? MaxReplacement : WindowDepth);

    localparam logic [CfgIndexWidth-1:0] CfgPatternBytes     = CfgIndexWidth'(0);
    localparam logic [CfgIndexWidth-1:0] CfgPatternLength    = CfgIndexWidth'(1);
    localparam logic [CfgIndexWidth-1:0] CfgReplacementBytes = CfgIndexWidth'(2);
    localparam logic [CfgIndexWidth-1:0] CfgReplacementLength = CfgIndexWidth'(3);

    typedef struct packed {
        logic                 has_run;
        logic [TextWidth-1:0] data;
        logic [LenWidth-1:0]  count;
        logic                 bare;
        logic                 stream_last;
    } run_t;

endpackage

FILE: sv/ssr_window.sv
`timescale 1ns / 1ps

module ssr_window
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   accept,
    input  logic [ssr_pkg::ByteWidth-1:0]          in_byte,
    input  logic                                   in_final,
    input  logic [ssr_pkg::TextWidth-1:0]          pattern_bytes,
    input  logic [ssr_pkg::LenWidth-1:0]           plen,
    input  logic [ssr_pkg::TextWidth-1:0]          replacement_bytes,
    input  logic [ssr_pkg::LenWidth-1:0]           rlen,
    output ssr_pkg::run_t                          run
);

    logic [ssr_pkg::TextWidth-1:0] win_reg;
    logic [ssr_pkg::TextWidth-1:0] win_next;
    logic [ssr_pkg::FillWidth-1:0] fill_reg;
    logic [ssr_pkg::FillWidth-1:0] fill_next;

    logic [ssr_pkg::TextWidth-1:0] win_a;
    logic [ssr_pkg::LenWidth-1:0]  fill_a;
    logic                          mismatch;
    logic                          match_hit;

    always_comb
    begin
        win_a = win_reg;
        win_a[{fill_reg, 3'b000} +: ssr_pkg::ByteWidth] = in_byte;
        fill_a = {1'b0, fill_reg} + ssr_pkg::LenWidth'(1);
    end

    always_comb
    begin
        mismatch = 1'b0;
        for (int i = 0; i < ssr_pkg::WindowDepth; i++)
        begin
            if ((ssr_pkg::LenWidth'(i) < plen) &&
                (win_a[i*ssr_pkg::ByteWidth +: ssr_pkg::ByteWidth] !=
                 pattern_bytes[i*ssr_pkg::ByteWidth +: ssr_pkg::ByteWidth]))
            begin
                mismatch = 1'b1;
            end
        end
        match_hit = (fill_a == plen) && !mismatch;
    end

    always_comb
    begin
        run.has_run     = 1'b0;
        run.data        = win_a;
        run.count       = fill_a;
        run.bare        = 1'b0;
        run.stream_last = in_final;
        win_next        = win_a;
        fill_next       = '0;
        priority if (match_hit)
        begin
            run.data = replacement_bytes;
            if (rlen != '0)
            begin
                run.has_run = 1'b1;
                run.count   = rlen;
            end
            else if (in_final)
            begin
                run.has_run = 1'b1;
                run.count   = ssr_pkg::LenWidth'(1);
                run.bare    = 1'b1;
            end
        end
        else if ((fill_a > plen) || in_final)
        begin
            run.has_run = 1'b1;
        end
        else if (fill_a == plen)
        begin
            run.has_run = 1'b1;
            run.count   = ssr_pkg::LenWidth'(1);
            win_next    = win_a >> ssr_pkg::ByteWidth;
            fill_next   = ssr_pkg::FillWidth'(fill_a - ssr_pkg::LenWidth'(1));
        end
        else
        begin
            fill_next = fill_a[ssr_pkg::FillWidth-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            fill_reg <= '0;
        end
        else if (accept)
        begin
            win_reg  <= win_next;
            fill_reg <= fill_next;
        end
    end

endmodule

FILE: sv/stream_substring_replace_top.sv
`timescale 1ns / 1ps

// Channel  Handshake             Payload
// in       in_valid / in_stall   in_byte, in_final
// out      out_valid / out_stall out_byte, byte_valid, run_end, stream_end
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A byte is matched against the pattern in the cycle it is accepted, and any
// run of results it completes is registered and appears at the output in the next cycle.
// The output gives one result per cycle while out_stall is low, so a run of several results
// holds off the input until its last result is taken; one result per byte sustains one byte per cycle.
// Reset empties the window and the output run and clears all registers.
// A stalled output holds its result; the input stalls only behind a run.
module stream_substring_replace_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [ssr_pkg::ByteWidth-1:0]        in_byte,
    input  logic                                 in_final,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [ssr_pkg::ByteWidth-1:0]        out_byte,
    output logic                                 byte_valid,
    output logic                                 run_end,
    output logic                                 stream_end,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ssr_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [ssr_pkg::TextWidth-1:0]        cfg_data
);

    logic [ssr_pkg::TextWidth-1:0] pattern_bytes_reg;
    logic [ssr_pkg::LenWidth-1:0]  pattern_length_reg;
    logic [ssr_pkg::TextWidth-1:0] replacement_bytes_reg;
    logic [ssr_pkg::LenWidth-1:0]  replacement_length_reg;
    logic [ssr_pkg::LenWidth-1:0]  plen;
    logic [ssr_pkg::LenWidth-1:0]  rlen;

    logic                          run_valid_reg;
    logic [ssr_pkg::TextWidth-1:0] run_data_reg;
    logic [ssr_pkg::LenWidth-1:0]  run_count_reg;
    logic [ssr_pkg::FillWidth-1:0] run_idx_reg;
    logic                          run_bare_reg;
    logic                          run_last_reg;

    logic                          accept;
    logic                          take;
    logic                          last_elem;
    ssr_pkg::run_t                 run;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= '0;
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ssr_pkg::CfgPatternBytes:
                    pattern_bytes_reg <= cfg_data;
                ssr_pkg::CfgPatternLength:
                    pattern_length_reg <= cfg_data[ssr_pkg::LenWidth-1:0];
                ssr_pkg::CfgReplacementBytes:
                    replacement_bytes_reg <= cfg_data;
                ssr_pkg::CfgReplacementLength:
                    replacement_length_reg <= cfg_data[ssr_pkg::LenWidth-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign plen = (pattern_length_reg > ssr_pkg::PatLimit) ?
                  ssr_pkg::PatLimit : pattern_length_reg;
    assign rlen = (replacement_length_reg > ssr_pkg::ReplLimit) ?
                  ssr_pkg::ReplLimit : replacement_length_reg;

    assign last_elem = ({1'b0, run_idx_reg} == (run_count_reg - ssr_pkg::LenWidth'(1)));
    assign take      = run_valid_reg && !out_stall;
    assign in_stall  = run_valid_reg && !(take && last_elem);
    assign accept    = in_valid && !in_stall;

    ssr_window u_window
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .in_byte           (in_byte),
        .in_final          (in_final),
        .pattern_bytes     (pattern_bytes_reg),
        .plen              (plen),
        .replacement_bytes (replacement_bytes_reg),
        .rlen              (rlen),
        .run               (run)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            run_idx_reg   <= '0;
        end
        else if (accept && run.has_run)
        begin
            run_valid_reg <= 1'b1;
            run_idx_reg   <= '0;
        end
        else if (take && last_elem)
        begin
            run_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            run_idx_reg <= run_idx_reg + ssr_pkg::FillWidth'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_data_reg  <= '0;
            run_count_reg <= '0;
            run_bare_reg  <= 1'b0;
            run_last_reg  <= 1'b0;
        end
        else if (accept && run.has_run)
        begin
            run_data_reg  <= run.data;
            run_count_reg <= run.count;
            run_bare_reg  <= run.bare;
            run_last_reg  <= run.stream_last;
        end
    end

    assign out_valid  = run_valid_reg;
    assign out_byte   = run_bare_reg ? '0 :
                        run_data_reg[{run_idx_reg, 3'b000} +: ssr_pkg::ByteWidth];
    assign byte_valid = !run_bare_reg;
    assign run_end    = last_elem;
    assign stream_end = last_elem && run_last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> (run_count_reg != '0) &&
                          (run_count_reg <= ssr_pkg::LenWidth'(ssr_pkg::WindowDepth)))
        else $error("run length out of range");

    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> ({1'b0, run_idx_reg} < run_count_reg))
        else $error("run index past run length");

    a_accept_only_at_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (run_valid_reg && !in_stall) |-> (!out_stall && last_elem))
        else $error("input taken while a run is still pending");

    a_bare_is_lone_end: assert property (@(posedge clk) disable iff (!rst_n)
        (run_valid_reg && run_bare_reg) |->
            (run_last_reg && (run_count_reg == ssr_pkg::LenWidth'(1))))
        else $error("bare end marker outside a final one-result run");

endmodule

FILE: tb/sv/stream_substring_replace_top_tb.sv
`timescale 1ns / 1ps

module stream_substring_replace_top_tb;

    localparam int StallLimit = 3000;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       run_last;
        logic       stream_last;
    } text_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [ssr_pkg::ByteWidth-1:0]     in_byte = '0;
    logic                              in_final = 1'b0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [ssr_pkg::ByteWidth-1:0]     out_byte;
    logic                              byte_valid;
    logic                              run_end;
    logic                              stream_end;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [ssr_pkg::CfgIndexWidth-1:0] cfg_index = '0;
    logic [ssr_pkg::TextWidth-1:0]     cfg_data = '0;

    logic [63:0]  pat_word = '0;
    logic [3:0]   pat_len = '0;
    logic [63:0]  rep_word = '0;
    logic [3:0]   rep_len = '0;
    logic [7:0]   window[8];
    int unsigned  window_fill = 0;

    text_result_t text_out_q[$];
    text_result_t want;
    int           errors = 0;
    int           idle_cycles = 0;
    int           rx_wait = 0;
    int           rx_hold = 0;
    bit           tx_idle = 1'b1;
    bit           rx_idle = 1'b1;

    stream_substring_replace_top u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .in_final   (in_final),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_end    (run_end),
        .stream_end (stream_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [7:0] take_oldest();
        logic [7:0] b;
        b = window[0];
        for (int i = 1; i < 8; i++)
        begin
            window[i - 1] = window[i];
        end
        window[7] = 8'h00;
        if (window_fill > 0)
        begin
            window_fill--;
        end
        return b;
    endfunction

    task automatic find_replace_byte(input logic [7:0] b, input logic fin);
        text_result_t run[$];
        int unsigned  plen;
        int unsigned  rlen;
        logic         hit;
        plen = (pat_len > 8) ? 8 : pat_len;
        rlen = (rep_len > 8) ? 8 : rep_len;
        if (window_fill >= 8)
        begin
            window_fill = 7;
        end
        window[window_fill] = b;
        window_fill++;
        if (window_fill > plen)
        begin
            while (window_fill > 0)
            begin
                run.push_back('{take_oldest(), 1'b1, 1'b0, 1'b0});
            end
        end
        else if (window_fill == plen)
        begin
            hit = 1'b1;
            for (int i = 0; i < plen; i++)
            begin
                if (window[i] != pat_word[i*8 +: 8])
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                for (int i = 0; i < rlen; i++)
                begin
                    run.push_back('{rep_word[i*8 +: 8], 1'b1, 1'b0, 1'b0});
                end
                foreach (window[i])
                begin
                    window[i] = 8'h00;
                end
                window_fill = 0;
            end
            else
            begin
                run.push_back('{take_oldest(), 1'b1, 1'b0, 1'b0});
            end
        end
        if (fin)
        begin
            while (window_fill > 0)
            begin
                run.push_back('{take_oldest(), 1'b1, 1'b0, 1'b0});
            end
            if (run.size() == 0)
            begin
                run.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
            end
            run[run.size() - 1].stream_last = 1'b1;
        end
        if (run.size() > 0)
        begin
            run[run.size() - 1].run_last = 1'b1;
        end
        foreach (run[i])
        begin
            text_out_q.push_back(run[i]);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= b;
        in_final <= fin;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        find_replace_byte(b, fin);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            ssr_pkg::CfgPatternBytes:      pat_word = val;
            ssr_pkg::CfgPatternLength:     pat_len = val[3:0];
            ssr_pkg::CfgReplacementBytes:  rep_word = val;
            ssr_pkg::CfgReplacementLength: rep_len = val[3:0];
            default:                       ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (text_out_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic test_pass_through();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
    endtask

    task automatic test_match_replace();
        drain_results();
        write_reg(ssr_pkg::CfgPatternBytes, 64'h6261);
        write_reg(ssr_pkg::CfgPatternLength, 64'd2);
        write_reg(ssr_pkg::CfgReplacementBytes, 64'h5A5958);
        write_reg(ssr_pkg::CfgReplacementLength, 64'd3);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b1);
    endtask

    task automatic test_empty_replacement();
        drain_results();
        write_reg(ssr_pkg::CfgReplacementLength, 64'd0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b1);
        send_byte(8'h61, 1'b1);
    endtask

    task automatic test_length_extremes();
        drain_results();
        write_reg(8'hFF, '1);
        write_reg(ssr_pkg::CfgPatternBytes, 64'h0);
        write_reg(ssr_pkg::CfgPatternLength, '1);
        write_reg(ssr_pkg::CfgReplacementBytes, '1);
        write_reg(ssr_pkg::CfgReplacementLength, 64'd15);
        for (int i = 0; i < 9; i++)
        begin
            send_byte(8'h00, i == 8);
        end
    endtask

    task automatic test_length_change();
        drain_results();
        write_reg(ssr_pkg::CfgPatternLength, 64'd4);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        drain_results();
        write_reg(ssr_pkg::CfgPatternLength, 64'd1);
        send_byte(8'h03, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_output_backpressure();
        drain_results();
        write_reg(ssr_pkg::CfgPatternBytes, 64'h71);
        write_reg(ssr_pkg::CfgPatternLength, 64'd1);
        write_reg(ssr_pkg::CfgReplacementBytes, {$urandom, $urandom});
        write_reg(ssr_pkg::CfgReplacementLength, 64'd8);
        drain_results();
        tx_idle = 1'b0;
        rx_hold = 80;
        for (int i = 0; i < 20; i++)
        begin
            send_byte(8'h71, i == 19);
        end
        drain_results();
        tx_idle = 1'b1;
    endtask

    task automatic test_random_streams();
        logic [7:0]  text[$];
        logic [7:0]  base;
        logic [63:0] word;
        int unsigned plen;
        int unsigned pick;
        int unsigned sent;
        for (int phase = 0; phase < 10; phase++)
        begin
            drain_results();
            tx_idle = (phase % 3) != 2;
            rx_idle = (phase % 4) != 3;
            base = 8'($urandom_range(0, 253));
            for (int k = 0; k < 8; k++)
            begin
                word[k*8 +: 8] = 8'(base + $urandom_range(0, 2));
            end
            plen = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 15);
            write_reg(ssr_pkg::CfgPatternBytes, word);
            write_reg(ssr_pkg::CfgPatternLength, 64'(plen));
            write_reg(ssr_pkg::CfgReplacementBytes, {$urandom, $urandom});
            write_reg(ssr_pkg::CfgReplacementLength, 64'($urandom_range(0, 15)));
            if ($urandom_range(0, 2) == 0)
            begin
                write_reg(8'($urandom_range(4, 255)), {$urandom, $urandom});
            end
            if (plen > 8)
            begin
                plen = 8;
            end
            sent = 0;
            while (sent < 17)
            begin
                text.delete();
                repeat ($urandom_range(1, 6))
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4)
                    begin
                        for (int k = 0; k < plen; k++)
                        begin
                            text.push_back(word[k*8 +: 8]);
                        end
                    end
                    else if (pick < 5)
                    begin
                        for (int k = 0; k + 1 < plen; k++)
                        begin
                            text.push_back(word[k*8 +: 8]);
                        end
                    end
                    else if (pick < 8)
                    begin
                        text.push_back(8'(base + $urandom_range(0, 2)));
                    end
                    else
                    begin
                        text.push_back(8'($urandom_range(0, 255)));
                    end
                end
                if (text.size() == 0)
                begin
                    text.push_back(8'($urandom_range(0, 255)));
                end
                foreach (text[i])
                begin
                    send_byte(text[i], i == text.size() - 1);
                end
                sent += text.size();
            end
        end
    endtask

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (text_out_q.size() == 0)
            begin
                $error("unexpected result: out_byte %0h byte_valid %0b", out_byte, byte_valid);
                errors++;
            end
            else
            begin
                want = text_out_q.pop_front();
                check_field("out_byte", 32'(want.data), 32'(out_byte));
                check_field("byte_valid", 32'(want.has_byte), 32'(byte_valid));
                check_field("run_end", 32'(want.run_last), 32'(run_end));
                check_field("stream_end", 32'(want.stream_last), 32'(stream_end));
            end
            rx_wait = rx_idle ? $urandom_range(0, 10) : 0;
        end
    end

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_stall <= 1'b1;
            rx_hold--;
        end
        else if (rx_wait > 0)
        begin
            out_stall <= 1'b1;
            rx_wait--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= StallLimit)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        foreach (window[i])
        begin
            window[i] = 8'h00;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_pass_through();
        test_match_replace();
        test_empty_replacement();
        test_length_extremes();
        test_length_change();
        test_output_backpressure();
        test_random_streams();
        drain_results();
        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
